/* sv/lnkjs_pkg.sv */
// Link join supervisor package: payload structs, register file struct,
// mode/error/link codes and the mode encoding function. No dependencies.
package lnkjs_pkg;

   localparam int unsigned MAX_NAME_LEN = 32;
   localparam int unsigned TIMER_W      = 20;
   localparam int unsigned THRESH_W     = 8;
   localparam int unsigned COUNT_W      = 32;
   localparam int unsigned CSR_DATA_W   = 20;
   localparam int unsigned CSR_INDEX_W  = 3;

   localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_JOIN_TIMEOUT  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DHCP_REGRAB   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REINIT_THRESH = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKOFF_FAIL  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKOFF_AUTH  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKOFF_DROP  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKOFF_START = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKOFF_REINIT = 3'd7;

   // register reset values
   localparam logic [TIMER_W-1:0]  RST_JOIN_TIMEOUT   = 20'd30000;
   localparam logic [TIMER_W-1:0]  RST_DHCP_REGRAB    = 20'd30000;
   localparam logic [THRESH_W-1:0] RST_REINIT_THRESH  = 8'd10;
   localparam logic [TIMER_W-1:0]  RST_BACKOFF_FAIL   = 20'd15000;
   localparam logic [TIMER_W-1:0]  RST_BACKOFF_AUTH   = 20'd60000;
   localparam logic [TIMER_W-1:0]  RST_BACKOFF_DROP   = 20'd2000;
   localparam logic [TIMER_W-1:0]  RST_BACKOFF_START  = 20'd5000;
   localparam logic [TIMER_W-1:0]  RST_BACKOFF_REINIT = 20'd60000;

   // request opcodes
   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_START = 1'b1;

   // sampled link status codes
   localparam logic [2:0] LINK_UP      = 3'd1;
   localparam logic [2:0] LINK_NONET   = 3'd2;
   localparam logic [2:0] LINK_BADAUTH = 3'd3;
   localparam logic [2:0] LINK_FAIL    = 3'd4;

   // mode codes as seen on the response
   localparam logic [1:0] MODE_CODE_IDLE    = 2'd0;
   localparam logic [1:0] MODE_CODE_JOINING = 2'd1;
   localparam logic [1:0] MODE_CODE_JOINED  = 2'd2;
   localparam logic [1:0] MODE_CODE_FAILED  = 2'd3;

   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_BAD_LENGTH = 3'd1,
      ERR_INTERNAL   = 3'd2,
      ERR_NO_NETWORK = 3'd3,
      ERR_AUTH       = 3'd4,
      ERR_TIMEOUT    = 3'd5
   } error_type;

   typedef enum logic [3:0] {
      MODE_IDLE    = 4'b0001,
      MODE_JOINING = 4'b0010,
      MODE_JOINED  = 4'b0100,
      MODE_FAILED  = 4'b1000
   } mode_state_type;

   typedef struct packed {
      logic       op;
      logic [7:0] ssid_length;
      logic [2:0] link_state;
      logic       ip_assigned;
      logic       interface_present;
      logic       connect_failed;
      logic       reinit_failed;
   } req_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [2:0]         error_code;
      logic [COUNT_W-1:0] retries;
      logic [COUNT_W-1:0] failures;
      logic               issue_connect;
      logic               issue_reinit;
      logic               issue_dhcp_restart;
   } rsp_type;

   typedef struct packed {
      logic [TIMER_W-1:0]  join_timeout;
      logic [TIMER_W-1:0]  dhcp_regrab;
      logic [THRESH_W-1:0] reinit_threshold;
      logic [TIMER_W-1:0]  backoff_fail;
      logic [TIMER_W-1:0]  backoff_auth;
      logic [TIMER_W-1:0]  backoff_drop;
      logic [TIMER_W-1:0]  backoff_start;
      logic [TIMER_W-1:0]  backoff_reinit;
   } cfg_type;

   function automatic logic [1:0] mode_code(input mode_state_type m);
      logic [1:0] code;
      case (m)
         MODE_JOINING: code = MODE_CODE_JOINING;
         MODE_JOINED:  code = MODE_CODE_JOINED;
         MODE_FAILED:  code = MODE_CODE_FAILED;
         default:      code = MODE_CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

/* sv/link_join_supervisor_top.sv */
// Link join supervisor top level: request register, update logic, response
// register and register file. Depends on lnkjs_pkg, lnkjs_csr, lnkjs_step.
//
//  port group   direction  handshake              payload
//  req_*        in         req_valid/req_ready    lnkjs_pkg::req_type
//  rsp_*        out        rsp_valid/rsp_ready    lnkjs_pkg::rsp_type
//  csr_*        in         csr_write_enable       csr_index, csr_write_data
//
// One request per cycle sustained while responses are taken; a taken request
// passes through the request register and then the response register.
// The state update runs as the request moves into the response register, so
// the next request sees it in the following cycle.
// Reset is synchronous and restores the mode machine, counters and registers.
// A stalled response holds; requests keep flowing while the response
// register frees in the same cycle.
module link_join_supervisor_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  lnkjs_pkg::req_type                 req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output lnkjs_pkg::rsp_type                 rsp_payload,
   input  logic                               csr_write_enable,
   input  logic [lnkjs_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [lnkjs_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   lnkjs_pkg::cfg_type cfg;
   lnkjs_pkg::req_type in_item_ff;
   lnkjs_pkg::rsp_type out_item_ff;
   lnkjs_pkg::rsp_type step_result;
   logic               in_valid_ff, in_valid_in;
   logic               out_valid_ff, out_valid_in;
   logic               accept_in;
   logic               advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign accept_in = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept_in) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept_in) begin
         in_item_ff <= req_payload;
      end
      if (advance) begin
         out_item_ff <= step_result;
      end
   end

   lnkjs_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   lnkjs_step u_step (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .item_advance (advance),
      .item         (in_item_ff),
      .result       (step_result)
   );

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

endmodule

/* sv/lnkjs_csr.sv */
// Link join supervisor register file: eight write-only settings.
// Depends on lnkjs_pkg.
module lnkjs_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [lnkjs_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [lnkjs_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output lnkjs_pkg::cfg_type                   cfg
);

   lnkjs_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            lnkjs_pkg::CSR_JOIN_TIMEOUT:   cfg_in.join_timeout   = csr_write_data;
            lnkjs_pkg::CSR_DHCP_REGRAB:    cfg_in.dhcp_regrab    = csr_write_data;
            lnkjs_pkg::CSR_REINIT_THRESH:
               cfg_in.reinit_threshold = csr_write_data[lnkjs_pkg::THRESH_W-1:0];
            lnkjs_pkg::CSR_BACKOFF_FAIL:   cfg_in.backoff_fail   = csr_write_data;
            lnkjs_pkg::CSR_BACKOFF_AUTH:   cfg_in.backoff_auth   = csr_write_data;
            lnkjs_pkg::CSR_BACKOFF_DROP:   cfg_in.backoff_drop   = csr_write_data;
            lnkjs_pkg::CSR_BACKOFF_START:  cfg_in.backoff_start  = csr_write_data;
            lnkjs_pkg::CSR_BACKOFF_REINIT: cfg_in.backoff_reinit = csr_write_data;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.join_timeout     <= lnkjs_pkg::RST_JOIN_TIMEOUT;
         cfg_ff.dhcp_regrab      <= lnkjs_pkg::RST_DHCP_REGRAB;
         cfg_ff.reinit_threshold <= lnkjs_pkg::RST_REINIT_THRESH;
         cfg_ff.backoff_fail     <= lnkjs_pkg::RST_BACKOFF_FAIL;
         cfg_ff.backoff_auth     <= lnkjs_pkg::RST_BACKOFF_AUTH;
         cfg_ff.backoff_drop     <= lnkjs_pkg::RST_BACKOFF_DROP;
         cfg_ff.backoff_start    <= lnkjs_pkg::RST_BACKOFF_START;
         cfg_ff.backoff_reinit   <= lnkjs_pkg::RST_BACKOFF_REINIT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* sv/lnkjs_step.sv */
// Link join supervisor state and per-request update: mode machine, timers,
// retry/failure counters and action requests. Depends on lnkjs_pkg.
module lnkjs_step (
   input  logic                clock,
   input  logic                reset,
   input  lnkjs_pkg::cfg_type  cfg,
   input  logic                item_advance,
   input  lnkjs_pkg::req_type  item,
   output lnkjs_pkg::rsp_type  result
);

   lnkjs_pkg::mode_state_type              mode_ff, mode_in;
   lnkjs_pkg::error_type                   error_ff, error_in;
   logic                                   cred_ff, cred_in;
   logic                                   noip_armed_ff, noip_armed_in;
   logic [lnkjs_pkg::TIMER_W-1:0]          join_elapsed_ff, join_elapsed_in;
   logic [lnkjs_pkg::TIMER_W-1:0]          retry_remaining_ff, retry_remaining_in;
   logic [lnkjs_pkg::TIMER_W-1:0]          noip_elapsed_ff, noip_elapsed_in;
   logic [lnkjs_pkg::COUNT_W-1:0]          retry_count_ff, retry_count_in;
   logic [lnkjs_pkg::COUNT_W-1:0]          failure_count_ff, failure_count_in;

   logic do_connect, do_reinit, do_dhcp;
   logic name_bad;
   logic [lnkjs_pkg::TIMER_W-1:0] join_inc, noip_inc, retry_dec;
   logic [lnkjs_pkg::COUNT_W-1:0] thresh_ext;

   // saturating timer increments and decrement
   assign join_inc = (join_elapsed_ff == lnkjs_pkg::TIMER_MAX) ?
                     join_elapsed_ff : join_elapsed_ff + 1'b1;
   assign noip_inc = (noip_elapsed_ff == lnkjs_pkg::TIMER_MAX) ?
                     noip_elapsed_ff : noip_elapsed_ff + 1'b1;
   assign retry_dec = (retry_remaining_ff != '0) ?
                      retry_remaining_ff - 1'b1 : retry_remaining_ff;
   assign thresh_ext = {{(lnkjs_pkg::COUNT_W-lnkjs_pkg::THRESH_W){1'b0}},
                        cfg.reinit_threshold};
   assign name_bad = (item.ssid_length == 8'd0) ||
                     (item.ssid_length > 8'(lnkjs_pkg::MAX_NAME_LEN));

   always_comb begin
      mode_in            = mode_ff;
      error_in           = error_ff;
      cred_in            = cred_ff;
      noip_armed_in      = noip_armed_ff;
      join_elapsed_in    = join_elapsed_ff;
      retry_remaining_in = retry_remaining_ff;
      noip_elapsed_in    = noip_elapsed_ff;
      retry_count_in     = retry_count_ff;
      failure_count_in   = failure_count_ff;
      do_connect         = 1'b0;
      do_reinit          = 1'b0;
      do_dhcp            = 1'b0;

      if (item.op == lnkjs_pkg::OP_START) begin
         if (name_bad) begin
            mode_in  = lnkjs_pkg::MODE_FAILED;
            error_in = lnkjs_pkg::ERR_BAD_LENGTH;
         end else begin
            cred_in          = 1'b1;
            mode_in          = lnkjs_pkg::MODE_JOINING;
            error_in         = lnkjs_pkg::ERR_NONE;
            join_elapsed_in  = '0;
            retry_count_in   = '0;
            failure_count_in = '0;
            noip_armed_in    = 1'b0;
            do_connect       = 1'b1;
            if (item.connect_failed) begin
               mode_in            = lnkjs_pkg::MODE_FAILED;
               error_in           = lnkjs_pkg::ERR_INTERNAL;
               retry_remaining_in = cfg.backoff_start;
               failure_count_in   = 32'd1;
            end
         end
      end else begin
         case (mode_ff)
            lnkjs_pkg::MODE_JOINED: begin
               if (item.link_state != lnkjs_pkg::LINK_UP) begin
                  // link dropped: no failure count for this cause
                  mode_in            = lnkjs_pkg::MODE_FAILED;
                  error_in           = lnkjs_pkg::ERR_INTERNAL;
                  retry_remaining_in = cfg.backoff_drop;
                  noip_armed_in      = 1'b0;
               end else if (!(item.interface_present && item.ip_assigned)) begin
                  if (!noip_armed_ff) begin
                     noip_armed_in   = 1'b1;
                     noip_elapsed_in = '0;
                  end else begin
                     noip_elapsed_in = noip_inc;
                     if (noip_inc > cfg.dhcp_regrab) begin
                        do_dhcp       = item.interface_present;
                        noip_armed_in = 1'b0;
                     end
                  end
               end else begin
                  noip_armed_in = 1'b0;
               end
            end
            lnkjs_pkg::MODE_JOINING: begin
               if (item.link_state == lnkjs_pkg::LINK_UP) begin
                  mode_in          = lnkjs_pkg::MODE_JOINED;
                  failure_count_in = '0;
               end else if (item.link_state == lnkjs_pkg::LINK_NONET) begin
                  mode_in            = lnkjs_pkg::MODE_FAILED;
                  error_in           = lnkjs_pkg::ERR_NO_NETWORK;
                  retry_remaining_in = cfg.backoff_fail;
                  failure_count_in   = failure_count_ff + 1'b1;
               end else if (item.link_state == lnkjs_pkg::LINK_BADAUTH) begin
                  mode_in            = lnkjs_pkg::MODE_FAILED;
                  error_in           = lnkjs_pkg::ERR_AUTH;
                  retry_remaining_in = cfg.backoff_auth;
                  failure_count_in   = failure_count_ff + 1'b1;
               end else if (item.link_state == lnkjs_pkg::LINK_FAIL) begin
                  mode_in            = lnkjs_pkg::MODE_FAILED;
                  error_in           = lnkjs_pkg::ERR_INTERNAL;
                  retry_remaining_in = cfg.backoff_fail;
                  failure_count_in   = failure_count_ff + 1'b1;
               end else begin
                  join_elapsed_in = join_inc;
                  if (join_inc > cfg.join_timeout) begin
                     mode_in            = lnkjs_pkg::MODE_FAILED;
                     error_in           = lnkjs_pkg::ERR_TIMEOUT;
                     retry_remaining_in = cfg.backoff_fail;
                     failure_count_in   = failure_count_ff + 1'b1;
                  end
               end
            end
            lnkjs_pkg::MODE_FAILED: begin
               retry_remaining_in = retry_dec;
               if (cred_ff && (retry_dec == '0)) begin
                  if (failure_count_ff >= thresh_ext) begin
                     do_reinit = 1'b1;
                     if (!item.reinit_failed) begin
                        failure_count_in = '0;
                     end
                  end
                  if (!(do_reinit && item.reinit_failed)) begin
                     retry_count_in  = retry_count_ff + 1'b1;
                     join_elapsed_in = '0;
                     mode_in         = lnkjs_pkg::MODE_JOINING;
                     do_connect      = 1'b1;
                     if (item.connect_failed) begin
                        mode_in            = lnkjs_pkg::MODE_FAILED;
                        error_in           = lnkjs_pkg::ERR_INTERNAL;
                        retry_remaining_in = cfg.backoff_fail;
                        failure_count_in   = failure_count_in + 1'b1;
                     end
                  end else begin
                     // reinit failed: wait out the reinit backoff
                     retry_remaining_in = cfg.backoff_reinit;
                  end
               end
            end
            default: begin
               // idle: ticks change nothing
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff            <= lnkjs_pkg::MODE_IDLE;
         error_ff           <= lnkjs_pkg::ERR_NONE;
         cred_ff            <= 1'b0;
         noip_armed_ff      <= 1'b0;
         join_elapsed_ff    <= '0;
         retry_remaining_ff <= '0;
         noip_elapsed_ff    <= '0;
         retry_count_ff     <= '0;
         failure_count_ff   <= '0;
      end else if (item_advance) begin
         mode_ff            <= mode_in;
         error_ff           <= error_in;
         cred_ff            <= cred_in;
         noip_armed_ff      <= noip_armed_in;
         join_elapsed_ff    <= join_elapsed_in;
         retry_remaining_ff <= retry_remaining_in;
         noip_elapsed_ff    <= noip_elapsed_in;
         retry_count_ff     <= retry_count_in;
         failure_count_ff   <= failure_count_in;
      end
   end

   always_comb begin
      result.mode               = lnkjs_pkg::mode_code(mode_in);
      result.error_code         = error_in;
      result.retries            = retry_count_in;
      result.failures           = failure_count_in;
      result.issue_connect      = do_connect;
      result.issue_reinit       = do_reinit;
      result.issue_dhcp_restart = do_dhcp;
   end

endmodule

/* sv/lnkjs_checker.sv */
// Port-level checks for the link join supervisor, bound to the top level.
// Depends on lnkjs_pkg and link_join_supervisor_top.
module lnkjs_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  lnkjs_pkg::rsp_type                 rsp_payload
);

   // no response survives reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled response changed");

   // a reinit is followed by a retry or leaves the link failed
   a_reinit_outcome: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.issue_reinit |->
         rsp_payload.issue_connect || (rsp_payload.mode == lnkjs_pkg::MODE_CODE_FAILED))
      else $error("reinit without retry or failed mode");

   // DHCP restart only while joined, never with a connect
   a_dhcp_joined: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.issue_dhcp_restart |->
         (rsp_payload.mode == lnkjs_pkg::MODE_CODE_JOINED) && !rsp_payload.issue_connect)
      else $error("DHCP restart outside joined mode");

   // idle is left for good at the first start; it carries no actions or errors
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_payload.mode == lnkjs_pkg::MODE_CODE_IDLE) |->
         !rsp_payload.issue_connect && !rsp_payload.issue_reinit &&
         (rsp_payload.error_code == lnkjs_pkg::ERR_NONE) && (rsp_payload.failures == '0))
      else $error("activity reported in idle mode");

endmodule

bind link_join_supervisor_top lnkjs_checker u_lnkjs_checker (.*);
